@@ sv/string_to_unsigned_parser_core_defines.svh @@
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_core_defines.svh
// Assertion macros used by the parser checker.
// ----------------------------------------------------------------------------
`ifndef STRING_TO_UNSIGNED_PARSER_CORE_DEFINES_SVH
`define STRING_TO_UNSIGNED_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STUP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STUP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

@@ sv/stup_pkg.sv @@
// ----------------------------------------------------------------------------
// stup_pkg
// Types, constants and character helpers for the string-to-unsigned parser.
// ----------------------------------------------------------------------------
package stup_pkg;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned MaxLenDefault = 255;
  localparam int unsigned OffsetWidth   = 8;
  localparam int unsigned BaseWidth     = 6;

  localparam logic [BaseWidth-1:0] RadixMax   = 6'd36;
  localparam logic [BaseWidth-1:0] RadixDec   = 6'd10;
  localparam logic [BaseWidth-1:0] RadixOct   = 6'd8;
  localparam logic [BaseWidth-1:0] RadixHex   = 6'd16;
  localparam logic [BaseWidth-1:0] RadixMin   = 6'd2;
  localparam logic [BaseWidth-1:0] RadixBad   = 6'd1;
  localparam logic [BaseWidth-1:0] RadixAuto  = 6'd0;
  localparam logic [BaseWidth-1:0] ResetBase  = 6'd10;
  localparam logic [BaseWidth-1:0] NoDigit    = 6'd63;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChLowerX = 8'h78;
  localparam logic [7:0] ChUpperX = 8'h58;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_START,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_CONV = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef struct packed {
    logic [ValueWidth-1:0]  value;
    logic [OffsetWidth-1:0] end_offset;
    status_e                status;
  } result_t;

  // Digit value of a character, NoDigit when it is none.
  function automatic logic [BaseWidth-1:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
    end else if (c >= ChUpperA && c <= ChUpperZ) begin
      t = c - ChUpperA + 8'd10;
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      t = c - ChLowerA + 8'd10;
    end else begin
      t = {2'b00, NoDigit};
    end
    return t[BaseWidth-1:0];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

endpackage

@@ sv/stup_mac.sv @@
// ----------------------------------------------------------------------------
// stup_mac
// Digit decode, multiply-add and overflow detect for one character.
// ----------------------------------------------------------------------------
module stup_mac
  import stup_pkg::*;
(
  input  logic [BaseWidth-1:0]  base_i,
  input  logic [7:0]            ch_i,
  input  logic [ValueWidth-1:0] acc_i,
  output logic                  is_digit_o,
  output logic                  ovf_o,
  output logic [ValueWidth-1:0] acc_o
);

  localparam int unsigned SumWidth = ValueWidth + BaseWidth + 1;

  logic [BaseWidth-1:0] radix;
  logic [BaseWidth-1:0] digit;
  logic [SumWidth-1:0]  sum;

  // a base below two only reaches here when the digit is rejected anyway
  assign radix      = (base_i < RadixMin) ? RadixMin : base_i;
  assign digit      = digit_of(ch_i);
  assign is_digit_o = (digit < radix);

  // acc*b + d overflows exactly when it no longer fits the value width
  assign sum   = ({{(BaseWidth+1){1'b0}}, acc_i} * {{(ValueWidth+1){1'b0}}, radix})
               + {{(ValueWidth+1){1'b0}}, digit};
  assign ovf_o = |sum[SumWidth-1:ValueWidth];
  assign acc_o = sum[ValueWidth-1:0];

endmodule

@@ sv/stup_ctrl.sv @@
// ----------------------------------------------------------------------------
// stup_ctrl
// Per-string parse state: phase machine, accumulator, offsets, result build.
// ----------------------------------------------------------------------------
module stup_ctrl
  import stup_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           ch_i,
  input  logic [BaseWidth-1:0] base_cfg_i,
  output result_t              res_o
);

  localparam int unsigned PosWidth = $clog2(MAX_LEN + 1);
  localparam logic [PosWidth-1:0] PosMax = PosWidth'(MAX_LEN);

  phase_e                phase_q, phase_d;
  logic                  minus_q, minus_d;
  logic                  ovf_q, ovf_d;
  logic [ValueWidth-1:0] acc_q, acc_d;
  logic [PosWidth-1:0]   pos_q, pos_d;
  logic [PosWidth-1:0]   stop_q, stop_d;
  logic [BaseWidth-1:0]  ab_q, ab_d;

  logic [BaseWidth-1:0]  ab_cur;
  logic [PosWidth-1:0]   consumed;
  logic                  is_nul;
  logic                  base_bad;
  logic                  zero_pref;
  logic                  take_en;
  logic [BaseWidth-1:0]  take_base;
  logic                  mac_digit;
  logic                  mac_ovf;
  logic [ValueWidth-1:0] mac_acc;
  logic                  ovf_any;
  logic [PosWidth+OffsetWidth-1:0] off_ext;

  // base is latched from the register on the first character of a string
  assign ab_cur    = (phase_q == PH_SPACE && pos_q == '0) ? base_cfg_i : ab_q;
  assign consumed  = (pos_q >= PosMax) ? PosMax : pos_q + 1'b1;
  assign is_nul    = (ch_i == ChNul);
  assign base_bad  = (ab_cur == RadixBad) || (ab_cur > RadixMax);
  assign zero_pref = (ch_i == ChZero) && (ab_cur == RadixAuto || ab_cur == RadixHex);
  assign ovf_any   = ovf_q | mac_ovf;

  // which base a digit is tried against, if any
  always_comb begin
    take_en   = 1'b0;
    take_base = ab_cur;
    case (phase_q)
      PH_SPACE, PH_START: begin
        if ((phase_q == PH_START || !(is_space(ch_i) || ch_i == ChPlus || ch_i == ChMinus))
            && !base_bad && !zero_pref) begin
          take_en   = 1'b1;
          take_base = (ab_cur == RadixAuto) ? RadixDec : ab_cur;
        end
      end
      PH_ZERO: begin
        if (ch_i != ChLowerX && ch_i != ChUpperX) begin
          take_en   = 1'b1;
          take_base = (ab_cur == RadixAuto) ? RadixOct : ab_cur;
        end
      end
      PH_XSEEN: begin
        take_en   = 1'b1;
        take_base = RadixHex;
      end
      PH_DIGITS: begin
        take_en = 1'b1;
      end
      default: ;
    endcase
  end

  stup_mac u_mac (
    .base_i    (take_base),
    .ch_i      (ch_i),
    .acc_i     (acc_q),
    .is_digit_o(mac_digit),
    .ovf_o     (mac_ovf),
    .acc_o     (mac_acc)
  );

  always_comb begin
    phase_d = phase_q;
    minus_d = minus_q;
    ovf_d   = ovf_q;
    acc_d   = acc_q;
    pos_d   = pos_q;
    stop_d  = stop_q;
    ab_d    = ab_q;
    if (fire_i) begin
      if (is_nul) begin
        phase_d = PH_SPACE;
        minus_d = 1'b0;
        ovf_d   = 1'b0;
        acc_d   = '0;
        pos_d   = '0;
        stop_d  = '0;
        ab_d    = RadixAuto;
      end else begin
        pos_d = consumed;
        ab_d  = ab_cur;
        if (take_en) begin
          ab_d = take_base;
          if (mac_digit) begin
            ovf_d   = ovf_any;
            stop_d  = consumed;
            phase_d = PH_DIGITS;
            if (!ovf_any) begin
              acc_d = mac_acc;
            end
          end else begin
            phase_d = PH_DONE;
          end
        end else begin
          case (phase_q)
            PH_SPACE, PH_START: begin
              if (phase_q == PH_SPACE && is_space(ch_i)) begin
                phase_d = PH_SPACE;
              end else if (phase_q == PH_SPACE && (ch_i == ChPlus || ch_i == ChMinus)) begin
                minus_d = (ch_i == ChMinus);
                phase_d = PH_START;
              end else if (base_bad) begin
                phase_d = PH_DONE;
              end else begin
                // lone leading zero, possibly a hex prefix
                acc_d   = '0;
                stop_d  = consumed;
                phase_d = PH_ZERO;
              end
            end
            PH_ZERO: phase_d = PH_XSEEN;
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minus_q <= 1'b0;
      ovf_q   <= 1'b0;
      acc_q   <= '0;
      pos_q   <= '0;
      stop_q  <= '0;
      ab_q    <= RadixAuto;
    end else begin
      minus_q <= minus_d;
      ovf_q   <= ovf_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      stop_q  <= stop_d;
      ab_q    <= ab_d;
    end
  end

  assign off_ext = {{OffsetWidth{1'b0}}, stop_q};

  always_comb begin
    res_o.value      = '0;
    res_o.end_offset = '0;
    res_o.status     = ST_NO_CONV;
    if (stop_q != '0) begin
      res_o.end_offset = off_ext[OffsetWidth-1:0];
      if (ovf_q) begin
        res_o.value  = '1;
        res_o.status = ST_RANGE;
      end else begin
        res_o.value  = minus_q ? (ValueWidth'(0) - acc_q) : acc_q;
        res_o.status = ST_OK;
      end
    end
  end

endmodule

@@ sv/string_to_unsigned_parser_core.sv @@
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_core - streaming strtoul-style converter
// Result: an accepted NUL item passes the input stage, then loads the result
//   register, later only while an earlier result is still held in it.
// Throughput: one item per cycle unless a NUL waits on a held result; one multiply-add and overflow check a cycle.
// Reset: async active low; parse state cleared, base register back to 10.
// ----------------------------------------------------------------------------
module string_to_unsigned_parser_core
  import stup_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration: radix register
  input  logic                   cfg_we_i,
  input  logic [BaseWidth-1:0]   cfg_wdata_i,
  // character items
  input  logic                   ch_valid_i,
  output logic                   ch_ready_o,
  input  logic [7:0]             ch_i,
  // result items
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [ValueWidth-1:0]  value_o,
  output logic [OffsetWidth-1:0] end_offset_o,
  output logic [1:0]             status_o
);

  logic [BaseWidth-1:0] base_q;

  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       advance;
  logic       fire;
  logic       accept;

  result_t    res_comb;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;

  // Radix register, sampled by the parser at the first item of a string.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ResetBase;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Input stage. Ordinary characters always move on; a NUL only moves
  // on when the result register is empty or being drained this cycle.
  assign advance    = (ch_q != ChNul) || !out_valid_q || res_ready_i;
  assign fire       = in_valid_q && advance;
  assign ch_ready_o = !in_valid_q || advance;
  assign accept     = ch_valid_i && ch_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q <= ch_i;
    end
  end

  // Parse state and result formation.
  stup_ctrl #(
    .MAX_LEN(MAX_LEN)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .ch_i      (ch_q),
    .base_cfg_i(base_q),
    .res_o     (res_comb)
  );

  // Result register: loaded when a NUL leaves the input stage.
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && ch_q == ChNul) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && ch_q == ChNul) begin
      out_q <= res_comb;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign value_o      = out_q.value;
  assign end_offset_o = out_q.end_offset;
  assign status_o     = out_q.status;

endmodule

@@ sv/stup_checker.sv @@
// ----------------------------------------------------------------------------
// stup_checker
// Port-level checks on the parser core, bound to the top level.
// ----------------------------------------------------------------------------
`include "string_to_unsigned_parser_core_defines.svh"

module stup_checker
  import stup_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_we_i,
  input logic [BaseWidth-1:0]   cfg_wdata_i,
  input logic                   ch_valid_i,
  input logic                   ch_ready_o,
  input logic [7:0]             ch_i,
  input logic                   res_valid_o,
  input logic                   res_ready_i,
  input logic [ValueWidth-1:0]  value_o,
  input logic [OffsetWidth-1:0] end_offset_o,
  input logic [1:0]             status_o
);

  logic nul_accept;
  logic cfg_seen;

  assign nul_accept = ch_valid_i && ch_ready_o && (ch_i == ChNul);
  assign cfg_seen   = cfg_we_i && (cfg_wdata_i != RadixAuto || cfg_wdata_i == RadixAuto);

  // stalled result holds
  `STUP_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_o && !res_ready_i && !cfg_seen, res_valid_o && $stable(value_o) && $stable(status_o))

  // a failed conversion reports zero value and zero offset
  `STUP_ASSERT_NOW(a_no_conv, clk_i, rst_ni, res_valid_o && status_o == ST_NO_CONV, value_o == '0 && end_offset_o == '0)

  // out of range saturates to all ones
  `STUP_ASSERT_NOW(a_range, clk_i, rst_ni, res_valid_o && status_o == ST_RANGE, value_o == '1)

  // every accepted NUL has a result on show once it has passed the input stage into the result register
  `STUP_ASSERT_NOW(a_nul_result, clk_i, rst_ni, nul_accept, ##2 res_valid_o)

endmodule

bind string_to_unsigned_parser_core stup_checker u_stup_checker (.*);

@@ test/tb_string_to_unsigned_parser_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_string_to_unsigned_parser_core
// Feeds character strings to the streaming string-to-unsigned converter under
// several radix settings, predicts each result on the NUL and compares the
// value, end offset and status of every result in order.
// ----------------------------------------------------------------------------
module tb_string_to_unsigned_parser_core;
  import stup_pkg::*;

  typedef logic [7:0] text_t[$];

  // One directed string: radix to use, characters (NUL appended), and an
  // expected result typed in where it is obvious; otherwise the predictor.
  typedef struct {
    logic [BaseWidth-1:0] base;
    string                text;
    bit                   known;
    result_t              res;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_we_i     = 1'b0;
  logic [BaseWidth-1:0]   cfg_wdata_i  = '0;
  logic                   ch_valid_i   = 1'b0;
  logic                   ch_ready_o;
  logic [7:0]             ch_i         = '0;
  logic                   res_valid_o;
  logic                   res_ready_i  = 1'b0;
  logic [ValueWidth-1:0]  value_o;
  logic [OffsetWidth-1:0] end_offset_o;
  logic [1:0]             status_o;

  string_to_unsigned_parser_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .ch_valid_i   (ch_valid_i),
    .ch_ready_o   (ch_ready_o),
    .ch_i         (ch_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .value_o      (value_o),
    .end_offset_o (end_offset_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Parser prediction: own copy of the radix register and per-string state
  // --------------------------------------------------------------------------
  logic [BaseWidth-1:0]   radix_reg = ResetBase;
  phase_e                 scan_phase = PH_SPACE;
  logic                   neg_sign = 1'b0;
  logic                   out_of_range = 1'b0;
  logic [ValueWidth-1:0]  acc_val = '0;
  logic [OffsetWidth-1:0] char_pos = '0;
  logic [OffsetWidth-1:0] stop_pos = '0;
  logic [BaseWidth-1:0]   radix_now = '0;

  result_t pending_results[$];
  int      mismatch_cnt = 0;
  int      burst_left = 0;

  // Value of c as a digit in any radix up to 36; 99 when it is not one.
  function automatic int unsigned char_digit(input logic [7:0] c);
    if (c inside {[ChZero:ChNine]})     return c - ChZero;
    if (c inside {[ChUpperA:ChUpperZ]}) return c - ChUpperA + 10;
    if (c inside {[ChLowerA:ChLowerZ]}) return c - ChLowerA + 10;
    return 99;
  endfunction

  function automatic bit char_blank(input logic [7:0] c);
    return (c == ChSpace) || (c inside {[ChTab:ChCr]});
  endfunction

  task automatic clear_string();
    scan_phase   = PH_SPACE;
    neg_sign     = 1'b0;
    out_of_range = 1'b0;
    acc_val      = '0;
    char_pos     = '0;
    stop_pos     = '0;
    radix_now    = '0;
  endtask

  // Takes c as a digit of the active radix if it is one. Overflow is sticky
  // and freezes the accumulator; the digit still counts as consumed.
  function automatic bit accept_digit(input logic [7:0] c, input logic [7:0] used);
    int unsigned d;
    int unsigned b;
    logic [63:0] nxt;
    d = char_digit(c);
    b = (radix_now < RadixMin) ? 2 : radix_now;
    if (d >= b) return 1'b0;
    nxt = {32'd0, acc_val} * 64'(b) + 64'(d);
    if (nxt > 64'hFFFF_FFFF) out_of_range = 1'b1;
    if (!out_of_range) acc_val = nxt[ValueWidth-1:0];
    stop_pos = used;
    return 1'b1;
  endfunction

  // First character after blanks and sign: bad radix ends the parse, a '0'
  // may open a hex prefix in auto or radix-16 mode.
  task automatic start_subject(input logic [7:0] c, input logic [7:0] used);
    if (radix_now == RadixBad || radix_now > RadixMax) begin
      scan_phase = PH_DONE;
    end else if (c == ChZero && (radix_now == RadixAuto || radix_now == RadixHex)) begin
      acc_val    = '0;
      stop_pos   = used;
      scan_phase = PH_ZERO;
    end else begin
      if (radix_now == RadixAuto) radix_now = RadixDec;
      scan_phase = accept_digit(c, used) ? PH_DIGITS : PH_DONE;
    end
  endtask

  // One accepted character; on the NUL, hands back the converted result.
  task automatic parse_char(input logic [7:0] c, output bit produced, output result_t r);
    logic [7:0] used;
    produced = 1'b0;
    r        = '0;
    if (c == ChNul) begin
      produced = 1'b1;
      r.status = ST_NO_CONV;
      if (stop_pos != 0) begin
        r.end_offset = stop_pos;
        if (out_of_range) begin
          r.value  = '1;
          r.status = ST_RANGE;
        end else begin
          r.value  = neg_sign ? ~acc_val + 1'b1 : acc_val;
          r.status = ST_OK;
        end
      end
      clear_string();
    end else begin
      // radix is latched on the very first character of a string
      if (scan_phase == PH_SPACE && char_pos == 0) radix_now = radix_reg;
      used = (char_pos >= 8'(MaxLenDefault)) ? 8'(MaxLenDefault) : char_pos + 8'd1;
      case (scan_phase)
        PH_SPACE: begin
          if (!char_blank(c)) begin
            if (c == ChMinus || c == ChPlus) begin
              neg_sign   = (c == ChMinus);
              scan_phase = PH_START;
            end else begin
              start_subject(c, used);
            end
          end
        end
        PH_START: start_subject(c, used);
        PH_ZERO: begin
          if (c == ChLowerX || c == ChUpperX) begin
            scan_phase = PH_XSEEN;
          end else begin
            if (radix_now == RadixAuto) radix_now = RadixOct;
            scan_phase = accept_digit(c, used) ? PH_DIGITS : PH_DONE;
          end
        end
        PH_XSEEN: begin
          // prefix only stands if a hex digit follows
          radix_now  = RadixHex;
          scan_phase = accept_digit(c, used) ? PH_DIGITS : PH_DONE;
        end
        PH_DIGITS: begin
          if (!accept_digit(c, used)) scan_phase = PH_DONE;
        end
        default: ;
      endcase
      char_pos = used;
    end
  endtask

  // --------------------------------------------------------------------------
  // Character sender: bursts of random length, random gaps in between
  // --------------------------------------------------------------------------
  task automatic push_char(input logic [7:0] c, output result_t r);
    int unsigned gap;
    bit          produced;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        ch_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    ch_valid_i <= 1'b1;
    ch_i       <= c;
    do @(posedge clk_i); while (!ch_ready_o);
    parse_char(c, produced, r);
  endtask

  // Sends the characters and the closing NUL; queues the expected result.
  task automatic send_text(input text_t txt, input bit known, input result_t known_res);
    result_t r;
    foreach (txt[i]) push_char(txt[i], r);
    push_char(ChNul, r);
    pending_results.push_back(known ? known_res : r);
  endtask

  // Holds the sender until every result is back, plus the pipeline depth.
  task automatic wait_drained();
    ch_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Radix register write, only with the parser idle.
  task automatic set_base(input logic [BaseWidth-1:0] b);
    wait_drained();
    cfg_wdata_i <= b;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radix_reg = b;
  endtask

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return ChZero + 8'(d);
    return ($urandom_range(0, 1) ? ChUpperA : ChLowerA) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 5) == 0) ? ChSpace : ChTab + 8'($urandom_range(0, 4));
  endfunction

  // Mostly well-formed numbers with random content; some noise and some
  // broken strings (sign alone, dangling hex prefix, blank after sign).
  function automatic text_t make_text(input logic [BaseWidth-1:0] b);
    text_t       t;
    int unsigned kind;
    int unsigned n;
    int unsigned cap;
    int unsigned db;
    logic [63:0] span;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(0, 8)) t.push_back(8'($urandom_range(1, 255)));
      return t;
    end
    if (kind < 18) begin
      case ($urandom_range(0, 3))
        0: ;
        1: t.push_back($urandom_range(0, 1) ? ChMinus : ChPlus);
        2: begin
          t.push_back(ChZero);
          t.push_back($urandom_range(0, 1) ? ChLowerX : ChUpperX);
          t.push_back($urandom_range(0, 1) ? ChLowerA + 8'd6 : blank_char());
        end
        default: begin
          t.push_back(ChMinus);
          t.push_back(blank_char());
          t.push_back(digit_char($urandom_range(0, 9)));
        end
      endcase
      return t;
    end
    repeat ($urandom_range(0, 3)) t.push_back(blank_char());
    case ($urandom_range(0, 2))
      0: ;
      1: t.push_back(ChMinus);
      default: t.push_back(ChPlus);
    endcase
    db = (b >= RadixMin && b <= RadixMax) ? b : 10;
    if (b == RadixAuto) begin
      case ($urandom_range(0, 2))
        0: db = 10;
        1: begin
          db = 8;
          t.push_back(ChZero);
        end
        default: begin
          db = 16;
          t.push_back(ChZero);
          t.push_back($urandom_range(0, 1) ? ChLowerX : ChUpperX);
        end
      endcase
    end else if (b == RadixHex && $urandom_range(0, 1)) begin
      t.push_back(ChZero);
      t.push_back($urandom_range(0, 1) ? ChLowerX : ChUpperX);
    end
    // digits needed to pass 32 bits, so that the long strings land around the overflow point
    span = 64'd1;
    cap  = 0;
    while (span <= 64'hFFFF_FFFF) begin
      span = span * db;
      cap++;
    end
    n = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(cap - 1, cap + 1);
    repeat (n) t.push_back(digit_char($urandom_range(0, db - 1)));
    if ($urandom_range(0, 2) == 0) t.push_back(8'($urandom_range(1, 255)));
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Result receiver: stall pattern switches mode whenever stall_cnt wraps
  //   0 always ready, 1 random stalls, 2 short periodic, 3 long holds
  // --------------------------------------------------------------------------
  logic [6:0]  stall_cnt  = '0;
  int unsigned stall_mode = 0;

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: unexpected result value %h offset %0d status %0d",
                 $realtime, value_o, end_offset_o, status_o);
    end else begin
      want = pending_results.pop_front();
      if (value_o !== want.value || end_offset_o !== want.end_offset ||
          status_o !== want.status) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result mismatch: want %h/%0d/%0d got %h/%0d/%0d",
                   $realtime, want.value, want.end_offset, want.status,
                   value_o, end_offset_o, status_o);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) check_result();
      stall_cnt <= stall_cnt + 1'b1;
      if (stall_cnt == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       res_ready_i <= 1'b1;
        1:       res_ready_i <= ($urandom_range(0, 3) != 0);
        2:       res_ready_i <= (stall_cnt[2:0] < 3'd5);
        default: res_ready_i <= stall_cnt[4];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Directed strings: extremes, every radix class, prefix and sign cases
  // --------------------------------------------------------------------------
  dir_row_t dir_rows [0:24] = '{
    '{RadixDec,  "",                     1'b1, '{32'd0,         8'd0,  ST_NO_CONV}},
    '{RadixDec,  "0",                    1'b1, '{32'd0,         8'd1,  ST_OK}},
    '{RadixDec,  "4294967295",           1'b1, '{32'hFFFF_FFFF, 8'd10, ST_OK}},
    '{RadixDec,  "4294967296",           1'b1, '{32'hFFFF_FFFF, 8'd10, ST_RANGE}},
    '{RadixDec,  "  \t\n\013\014\r-1",   1'b0, '0},
    '{RadixDec,  "+",                    1'b1, '{32'd0,         8'd0,  ST_NO_CONV}},
    '{RadixDec,  "-",                    1'b1, '{32'd0,         8'd0,  ST_NO_CONV}},
    '{RadixDec,  "-99999999999",         1'b1, '{32'hFFFF_FFFF, 8'd12, ST_RANGE}},
    '{RadixAuto, "0x1F",                 1'b1, '{32'd31,        8'd4,  ST_OK}},
    '{RadixAuto, "0X",                   1'b0, '0},
    '{RadixAuto, "0xg",                  1'b0, '0},
    '{RadixAuto, "017",                  1'b0, '0},
    '{RadixAuto, "0",                    1'b0, '0},
    '{RadixAuto, "089",                  1'b0, '0},
    '{RadixAuto, " -123abc",             1'b0, '0},
    '{RadixHex,  "0xFFffFFff",           1'b0, '0},
    '{RadixHex,  "-0x",                  1'b0, '0},
    '{RadixMin,  "101012",               1'b0, '0},
    '{RadixMax,  "zZ",                   1'b0, '0},
    '{RadixBad,  "123",                  1'b1, '{32'd0,         8'd0,  ST_NO_CONV}},
    '{6'd37,     "12",                   1'b1, '{32'd0,         8'd0,  ST_NO_CONV}},
    '{6'd63,     "5",                    1'b1, '{32'd0,         8'd0,  ST_NO_CONV}},
    '{RadixDec,  "\200 12",              1'b0, '0},
    '{RadixDec,  "12\377",               1'b0, '0},
    '{6'd35,     "z",                    1'b0, '0}
  };

  logic [BaseWidth-1:0] phase_bases [0:8] = '{
    RadixAuto, RadixMin, RadixOct, RadixDec, RadixHex, RadixMax, RadixBad, 6'd37, 6'd63
  };

  initial begin
    text_t                txt;
    logic [BaseWidth-1:0] pb;
    int unsigned          sent;
    clear_string();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].base != radix_reg) set_base(dir_rows[i].base);
      txt = {};
      for (int j = 0; j < dir_rows[i].text.len(); j++) txt.push_back(dir_rows[i].text[j]);
      send_text(txt, dir_rows[i].known, dir_rows[i].res);
    end

    // Random phases, one radix each; the last few take any 6-bit value.
    for (int k = 0; k < 12; k++) begin
      pb = (k < 9) ? phase_bases[k] : BaseWidth'($urandom_range(0, 63));
      set_base(pb);
      // long strings push the offset into saturation
      txt = {};
      case (k)
        0: repeat (258) txt.push_back(ChZero);
        3: begin
          repeat (256) txt.push_back(blank_char());
          txt.push_back(ChZero + 8'd4);
          txt.push_back(ChZero + 8'd2);
        end
        default: ;
      endcase
      if (txt.size() != 0) send_text(txt, 1'b0, '0);
      sent = 0;
      while (sent < 34) begin
        txt = make_text(pb);
        sent += txt.size() + 1;
        send_text(txt, 1'b0, '0);
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
